// ----- src/kb_pkg.sv -----
// Shared types and constants for the Klein bottle point and tangent pipeline.
// No dependencies; used by every module of the block but kb_checker.
package kb_pkg;

  localparam int KB_ANGLE_FRAC_BITS = 12;
  localparam int KB_VALUE_FRAC_BITS = 16;
  localparam int KB_STEPS           = 24;
  localparam int KB_INT_FRAC        = 24;
  localparam int KB_TRIG_W          = 26;

  localparam logic signed [63:0] KB_INV_TWO_PI  = 64'sd683565276;
  localparam logic signed [31:0] KB_CORDIC_GAIN = 32'sd652032874;
  localparam logic [23:0]        KB_RADIUS_RST  = 24'd131072;

  localparam logic [29:0] KB_ATAN [KB_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  // State handed from one rotation cell to the next
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
    logic               neg;
  } kb_cordic_t;

endpackage

// ----- src/kb_cordic_cell.sv -----
// One rotation-mode CORDIC step, registered.
// Depends on kb_pkg for the cell state type and the arctangent table.
module kb_cordic_cell import kb_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       en,
  input  kb_cordic_t cin,
  output kb_cordic_t cout
);

  localparam logic signed [32:0] ATAN = $signed({3'b000, KB_ATAN[STEP]});

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  kb_cordic_t         cout_next;

  // rotate toward zero residual angle
  always_comb begin
    dx = cin.y >>> STEP;
    dy = cin.x >>> STEP;
    cout_next.neg = cin.neg;
    if (!cin.z[32]) begin
      cout_next.x = cin.x - dx;
      cout_next.y = cin.y + dy;
      cout_next.z = cin.z - ATAN;
    end else begin
      cout_next.x = cin.x + dx;
      cout_next.y = cin.y - dy;
      cout_next.z = cin.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= cout_next;
    end
  end

endmodule

// ----- src/kb_cordic_chain.sv -----
// Sine and cosine of a 32-bit phase: half-turn fold, a row of CORDIC cells,
// rounding to Q24. Depends on kb_pkg and kb_cordic_cell.
module kb_cordic_chain import kb_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic [31:0]                 phase,
  output logic signed [KB_TRIG_W-1:0] cos_val,
  output logic signed [KB_TRIG_W-1:0] sin_val
);

  kb_cordic_t         stage [KB_STEPS+1];
  kb_cordic_t         fold_next;
  logic [31:0]        ph_q;
  logic               neg;
  logic signed [32:0] xr;
  logic signed [32:0] yr;
  logic signed [KB_TRIG_W-1:0] cos_next;
  logic signed [KB_TRIG_W-1:0] sin_next;

  // phases in the left half-plane move by half a turn
  always_comb begin
    ph_q = phase + 32'h4000_0000;
    neg  = ph_q[31];
    fold_next.neg = neg;
    fold_next.x   = KB_CORDIC_GAIN;
    fold_next.y   = '0;
    fold_next.z   = $signed({phase[31] ^ neg, phase[31] ^ neg, phase[30:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= fold_next;
    end
  end

  // row of rotation cells
  for (genvar i = 0; i < KB_STEPS; i++) begin : g_cell
    kb_cordic_cell #(.STEP(i)) u_cell (
      .clk  (clk),
      .en   (en),
      .cin  (stage[i]),
      .cout (stage[i+1])
    );
  end

  // round Q30 to Q24 and undo the fold
  always_comb begin
    xr = ({stage[KB_STEPS].x[31], stage[KB_STEPS].x} + 33'sd32) >>> 6;
    yr = ({stage[KB_STEPS].y[31], stage[KB_STEPS].y} + 33'sd32) >>> 6;
    cos_next = stage[KB_STEPS].neg ? -xr[KB_TRIG_W-1:0] : xr[KB_TRIG_W-1:0];
    sin_next = stage[KB_STEPS].neg ? -yr[KB_TRIG_W-1:0] : yr[KB_TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= cos_next;
      sin_val <= sin_next;
    end
  end

endmodule

// ----- src/klein_bottle_point_and_tangents.sv -----
// Figure-eight Klein bottle point and tangent vectors from (u, v) angles.
// Depends on kb_pkg and kb_cordic_chain.
//
// Each transfer of (u_angle, v_angle) yields one transfer of the surface point
// and both partial derivatives. One item is accepted every cycle; the four
// sine/cosine chains of 24 CORDIC cells and the two multiply stages are fully
// pipelined. A stalled output holds the whole pipeline, so in_ready follows
// out_ready while a result waits. The user must write ring_radius through
// cfg_wr_en/cfg_wr_data while no item is in flight; the block does not check.
module klein_bottle_point_and_tangents import kb_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = KB_ANGLE_FRAC_BITS,
  parameter int VALUE_FRAC_BITS = KB_VALUE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] u_angle,
  input  logic signed [15:0] v_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] point_x,
  output logic signed [23:0] point_y,
  output logic signed [23:0] point_z,
  output logic signed [23:0] du_x,
  output logic signed [23:0] du_y,
  output logic signed [23:0] du_z,
  output logic signed [23:0] dv_x,
  output logic signed [23:0] dv_y,
  output logic signed [23:0] dv_z
);

  localparam int LAT  = 31;
  localparam int SH   = KB_INT_FRAC - VALUE_FRAC_BITS;
  localparam int RSH  = KB_INT_FRAC - VALUE_FRAC_BITS;
  localparam logic signed [63:0] HALF = (SH == 0) ? 64'sd0 : 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] RND_H = 64'sd1 <<< ANGLE_FRAC_BITS;
  localparam logic signed [63:0] RND_V = 64'sd1 <<< (ANGLE_FRAC_BITS - 1);

  localparam int TW = KB_TRIG_W;

  logic [23:0]    radius;
  logic [LAT-1:0] vld;
  logic           en;

  // global advance: a waiting result stalls every stage
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  // ring radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= KB_RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // valid bits track each item through the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // angle to phase, 2^32 per turn
  logic signed [63:0] pu;
  logic signed [63:0] pv;
  logic [31:0]        ph_h_next;
  logic [31:0]        ph_v_next;
  logic [31:0]        ph_h;
  logic [31:0]        ph_u;
  logic [31:0]        ph_v;
  logic [31:0]        ph_2v;

  always_comb begin
    pu = {{48{u_angle[15]}}, u_angle} * KB_INV_TWO_PI;
    pv = {{48{v_angle[15]}}, v_angle} * KB_INV_TWO_PI;
    ph_h_next = 32'((pu + RND_H) >>> (ANGLE_FRAC_BITS + 1));
    ph_v_next = 32'((pv + RND_V) >>> ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_h  <= ph_h_next;
      ph_u  <= {ph_h_next[30:0], 1'b0};
      ph_v  <= ph_v_next;
      ph_2v <= {ph_v_next[30:0], 1'b0};
    end
  end

  // four sine/cosine chains
  logic signed [TW-1:0] cu2, su2, cu, su, cv, sv, c2v, s2v;

  kb_cordic_chain u_trig_h (.clk(clk), .en(en), .phase(ph_h),  .cos_val(cu2), .sin_val(su2));
  kb_cordic_chain u_trig_u (.clk(clk), .en(en), .phase(ph_u),  .cos_val(cu),  .sin_val(su));
  kb_cordic_chain u_trig_v (.clk(clk), .en(en), .phase(ph_v),  .cos_val(cv),  .sin_val(sv));
  kb_cordic_chain u_trig_2 (.clk(clk), .en(en), .phase(ph_2v), .cos_val(c2v), .sin_val(s2v));

  // first products, Q24 rounded
  function automatic logic signed [29:0] mulq_t(logic signed [TW-1:0] p,
                                                logic signed [TW-1:0] q);
    logic signed [51:0] m;
    m = p * q;
    mulq_t = 30'((m + 52'sd8388608) >>> 24);
  endfunction

  logic signed [29:0] p_cs, p_ss2, p_sv, p_cs2, p_cc, p_sc2, p_scv, p_cc2;
  logic signed [TW-1:0] cu4, su4;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cs  <= mulq_t(cu2, sv);
      p_ss2 <= mulq_t(su2, s2v);
      p_sv  <= mulq_t(su2, sv);
      p_cs2 <= mulq_t(cu2, s2v);
      p_cc  <= mulq_t(cu2, cv);
      p_sc2 <= mulq_t(su2, c2v);
      p_scv <= mulq_t(su2, cv);
      p_cc2 <= mulq_t(cu2, c2v);
      cu4   <= cu;
      su4   <= su;
    end
  end

  // combine into R, Z, T, D and dz/dv
  logic signed [47:0] a_val;
  logic signed [47:0] r5;
  logic signed [31:0] zz5, t5, d5, dzv5;
  logic signed [TW-1:0] cu5, su5;

  assign a_val = {{24{radius[23]}}, radius} <<< RSH;

  always_ff @(posedge clk) begin
    if (en) begin
      r5   <= a_val + 48'(p_cs) - 48'(p_ss2);
      zz5  <= 32'(p_sv) + 32'(p_cs2);
      t5   <= 32'(p_cs) - 32'(p_ss2);
      d5   <= 32'(p_cc) - (32'(p_sc2) <<< 1);
      dzv5 <= 32'(p_scv) + (32'(p_cc2) <<< 1);
      cu5  <= cu4;
      su5  <= su4;
    end
  end

  // second products against cos(u), sin(u)
  logic signed [79:0] m_rc, m_rs, m_zc, m_zs, m_dc, m_ds;
  logic signed [59:0] q_rc, q_rs, h_zc, h_zs, q_dc, q_ds;
  logic signed [31:0] zz6, t6, dzv6;

  always_comb begin
    m_rc = 80'(r5) * 80'(cu5);
    m_rs = 80'(r5) * 80'(su5);
    m_zc = 80'(zz5) * 80'(cu5);
    m_zs = 80'(zz5) * 80'(su5);
    m_dc = 80'(d5) * 80'(cu5);
    m_ds = 80'(d5) * 80'(su5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_rc <= 60'((m_rc + 80'sd8388608) >>> 24);
      q_rs <= 60'((m_rs + 80'sd8388608) >>> 24);
      h_zc <= 60'((m_zc + 80'sd16777216) >>> 25);
      h_zs <= 60'((m_zs + 80'sd16777216) >>> 25);
      q_dc <= 60'((m_dc + 80'sd8388608) >>> 24);
      q_ds <= 60'((m_ds + 80'sd8388608) >>> 24);
      zz6  <= zz5;
      t6   <= t5;
      dzv6 <= dzv5;
    end
  end

  // scale to output format and saturate
  function automatic logic signed [23:0] sat_out(logic signed [59:0] w);
    logic signed [63:0] r;
    r = (64'(w) + HALF) >>> SH;
    if (r > 64'sd8388607) begin
      sat_out = 24'sh7FFFFF;
    end else if (r < -64'sd8388608) begin
      sat_out = 24'sh800000;
    end else begin
      sat_out = r[23:0];
    end
  endfunction

  logic signed [59:0] w_z, w_dux, w_duy, w_duz, w_dvz;

  always_comb begin
    w_z   = 60'(zz6);
    w_dux = -h_zc - q_rs;
    w_duy = -h_zs + q_rc;
    w_duz = (60'(t6) + 60'sd1) >>> 1;
    w_dvz = 60'(dzv6);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point_x <= sat_out(q_rc);
      point_y <= sat_out(q_rs);
      point_z <= sat_out(w_z);
      du_x    <= sat_out(w_dux);
      du_y    <= sat_out(w_duy);
      du_z    <= sat_out(w_duz);
      dv_x    <= sat_out(q_dc);
      dv_y    <= sat_out(q_ds);
      dv_z    <= sat_out(w_dvz);
    end
  end

endmodule

// ----- src/kb_checker.sv -----
// Port-level checks for klein_bottle_point_and_tangents, bound to the top.
// Depends on the top level's ports only.
module kb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] point_x,
  input logic signed [23:0] dv_z
);

  // nothing comes out right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // an empty output never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no pending result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(dv_z))
    else $error("stalled result changed");

  // a stalled result also blocks new input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

endmodule

bind klein_bottle_point_and_tangents kb_checker u_kb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .point_x   (point_x),
  .dv_z      (dv_z)
);
